### hdl/sscl_pkg.sv
// ----------------------------------------------------------------------------
// sscl_pkg
// Shared types, constants and helper functions for the four-joint servo
// slew-rate limiter.
// ----------------------------------------------------------------------------
package sscl_pkg;

  localparam int unsigned NUM_JOINTS = 4;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned STICK_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Joint limits and reset angles
  localparam int unsigned BASE_MAX_DEF     = 180;
  localparam int unsigned SHOULDER_MAX_DEF = 60;
  localparam int unsigned ELBOW_MAX_DEF    = 160;
  localparam int unsigned CLAMP_MAX_DEF    = 124;

  localparam logic [ANGLE_W-1:0] BASE_RESET     = 8'd0;
  localparam logic [ANGLE_W-1:0] SHOULDER_RESET = 8'd0;
  localparam logic [ANGLE_W-1:0] ELBOW_RESET    = 8'd160;
  localparam logic [ANGLE_W-1:0] CLAMP_RESET    = 8'd92;

  // Register reset values
  localparam logic [STICK_W-1:0] UPPER_RESET = 10'd680;
  localparam logic [STICK_W-1:0] LOWER_RESET = 10'd340;
  localparam logic [ANGLE_W-1:0] STEP_RESET  = 8'd4;
  localparam logic [ANGLE_W-1:0] BASE_RATE_RESET     = 8'd4;
  localparam logic [ANGLE_W-1:0] SHOULDER_RATE_RESET = 8'd1;
  localparam logic [ANGLE_W-1:0] ELBOW_RATE_RESET    = 8'd1;
  localparam logic [ANGLE_W-1:0] CLAMP_RATE_RESET    = 8'd4;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_MOVE   = 2'd1,
    FUNC_SETTLE = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER         = 3'd0,
    CFG_LOWER         = 3'd1,
    CFG_STEP          = 3'd2,
    CFG_BASE_RATE     = 3'd3,
    CFG_SHOULDER_RATE = 3'd4,
    CFG_ELBOW_RATE    = 3'd5,
    CFG_CLAMP_RATE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [STICK_W-1:0] stick_x;
    logic [STICK_W-1:0] stick_y;
    logic               elbow_down_pressed;
    logic               elbow_up_pressed;
    logic               clamp_open_pressed;
    logic               clamp_close_pressed;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] base_angle;
    logic [ANGLE_W-1:0] shoulder_angle;
    logic [ANGLE_W-1:0] elbow_angle;
    logic [ANGLE_W-1:0] clamp_angle;
    logic               all_settled;
  } out_item_t;

  typedef struct packed {
    logic [STICK_W-1:0]                   upper;
    logic [STICK_W-1:0]                   lower;
    logic [ANGLE_W-1:0]                   step;
    logic [NUM_JOINTS-1:0][ANGLE_W-1:0]   rate;
  } cfg_t;

  // Target command for one joint on a sample beat
  typedef struct packed {
    logic inc;
    logic dec;
    logic inc_first;
  } joint_cmd_t;

  // Raise a target by step, saturating at the joint maximum
  function automatic logic [ANGLE_W-1:0] raise_target(input logic [ANGLE_W-1:0] t,
                                                      input logic [ANGLE_W-1:0] step,
                                                      input logic [ANGLE_W-1:0] lim);
    logic [ANGLE_W:0] sum;
    sum = {1'b0, t} + {1'b0, step};
    return (sum > {1'b0, lim}) ? lim : sum[ANGLE_W-1:0];
  endfunction

  // Lower a target by step, saturating at zero
  function automatic logic [ANGLE_W-1:0] lower_target(input logic [ANGLE_W-1:0] t,
                                                      input logic [ANGLE_W-1:0] step);
    return (t > step) ? (t - step) : '0;
  endfunction

endpackage

### hdl/sscl_cfg_regs.sv
// ----------------------------------------------------------------------------
// sscl_cfg_regs
// Configuration register file: thresholds, target step and per-joint rates.
// ----------------------------------------------------------------------------
module sscl_cfg_regs
  import sscl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Decode the write and update one register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper   <= UPPER_RESET;
      cfg.lower   <= LOWER_RESET;
      cfg.step    <= STEP_RESET;
      cfg.rate[0] <= BASE_RATE_RESET;
      cfg.rate[1] <= SHOULDER_RATE_RESET;
      cfg.rate[2] <= ELBOW_RATE_RESET;
      cfg.rate[3] <= CLAMP_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER:         cfg.upper   <= cfg_data;
        CFG_LOWER:         cfg.lower   <= cfg_data;
        CFG_STEP:          cfg.step    <= cfg_data[ANGLE_W-1:0];
        CFG_BASE_RATE:     cfg.rate[0] <= cfg_data[ANGLE_W-1:0];
        CFG_SHOULDER_RATE: cfg.rate[1] <= cfg_data[ANGLE_W-1:0];
        CFG_ELBOW_RATE:    cfg.rate[2] <= cfg_data[ANGLE_W-1:0];
        CFG_CLAMP_RATE:    cfg.rate[3] <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/sscl_joint.sv
// ----------------------------------------------------------------------------
// sscl_joint
// One joint: target and actual angle registers with the sample, move and
// settle update logic.
// ----------------------------------------------------------------------------
module sscl_joint
  import sscl_pkg::*;
#(
  parameter int unsigned        MAX         = BASE_MAX_DEF,
  parameter logic [ANGLE_W-1:0] RESET_ANGLE = BASE_RESET
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [1:0]         func,
  input  joint_cmd_t         cmd,
  input  logic [ANGLE_W-1:0] step,
  input  logic [ANGLE_W-1:0] rate,
  output logic [ANGLE_W-1:0] actual_next,
  output logic               settled_next
);

  localparam logic [ANGLE_W-1:0] LIM = ANGLE_W'(MAX);

  logic [ANGLE_W-1:0] target;
  logic [ANGLE_W-1:0] actual;
  logic [ANGLE_W-1:0] target_next;
  logic [ANGLE_W-1:0] t_first;
  logic [ANGLE_W-1:0] t_second;
  logic [ANGLE_W-1:0] diff;
  logic [ANGLE_W-1:0] stepped;
  logic               far;

  // Apply the two target commands in the order this joint wants
  always_comb begin
    if (cmd.inc_first) begin
      t_first  = cmd.inc ? raise_target(target, step, LIM) : target;
      t_second = cmd.dec ? lower_target(t_first, step) : t_first;
    end else begin
      t_first  = cmd.dec ? lower_target(target, step) : target;
      t_second = cmd.inc ? raise_target(t_first, step, LIM) : t_first;
    end
  end

  // Distance and one rate step toward the target (wraps at 8 bits)
  assign diff    = (actual > target) ? (actual - target) : (target - actual);
  assign far     = {1'b0, diff} > {rate, 1'b0};
  assign stepped = (actual > target) ? (actual - rate) : (actual + rate);

  always_comb begin
    target_next = target;
    actual_next = actual;
    case (func)
      FUNC_SAMPLE: target_next = t_second;
      FUNC_MOVE:   actual_next = far ? stepped : actual;
      FUNC_SETTLE: actual_next = (actual != target) ? stepped : actual;
      default: ;
    endcase
  end

  assign settled_next = (actual_next == target_next);

  // Commit on each advancing beat
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= RESET_ANGLE;
      actual <= RESET_ANGLE;
    end else if (advance) begin
      target <= target_next;
      actual <= actual_next;
    end
  end

endmodule

### hdl/four_axis_servo_slew_control.sv
// ----------------------------------------------------------------------------
// four_axis_servo_slew_control
// Four-joint servo slew-rate limiter: joystick and buttons move the targets,
// ticks slew the actual angles toward them.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | in_item_t
//   out     | output    | out_valid/out_stall | out_item_t
//   cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low. Each beat is held in the
// input register, then the joint update logic commits the new angles and loads
// the result register, and out_valid rises when the beat advances.
// rst is synchronous and returns all angles to 0, 0, 160, 92 and the
// registers to their defaults. out_stall holds the result register; the input
// register keeps accepting until it is also full.
// ----------------------------------------------------------------------------
module four_axis_servo_slew_control
  import sscl_pkg::*;
#(
  parameter int unsigned BASE_MAX     = BASE_MAX_DEF,
  parameter int unsigned SHOULDER_MAX = SHOULDER_MAX_DEF,
  parameter int unsigned ELBOW_MAX    = ELBOW_MAX_DEF,
  parameter int unsigned CLAMP_MAX    = CLAMP_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                             cfg;
  in_item_t                         s1;
  logic                             s1_valid;
  logic                             advance;
  joint_cmd_t [NUM_JOINTS-1:0]      cmd;
  logic [NUM_JOINTS-1:0][ANGLE_W-1:0] act_next;
  logic [NUM_JOINTS-1:0]            set_next;
  logic                             x_up;
  logic                             y_up;

  sscl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline control
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  // Build target commands from sticks and buttons
  assign x_up = s1.stick_x > cfg.upper;
  assign y_up = s1.stick_y > cfg.upper;

  always_comb begin
    cmd[0] = '{inc: x_up, dec: !x_up && (s1.stick_x < cfg.lower), inc_first: 1'b1};
    cmd[1] = '{inc: y_up, dec: !y_up && (s1.stick_y < cfg.lower), inc_first: 1'b1};
    cmd[2] = '{inc: s1.elbow_up_pressed, dec: s1.elbow_down_pressed, inc_first: 1'b0};
    cmd[3] = '{inc: s1.clamp_open_pressed, dec: s1.clamp_close_pressed, inc_first: 1'b1};
  end

  sscl_joint #(.MAX(BASE_MAX), .RESET_ANGLE(BASE_RESET)) u_base (
    .clk (clk), .rst (rst), .advance (advance), .func (s1.func), .cmd (cmd[0]),
    .step (cfg.step), .rate (cfg.rate[0]),
    .actual_next (act_next[0]), .settled_next (set_next[0])
  );

  sscl_joint #(.MAX(SHOULDER_MAX), .RESET_ANGLE(SHOULDER_RESET)) u_shoulder (
    .clk (clk), .rst (rst), .advance (advance), .func (s1.func), .cmd (cmd[1]),
    .step (cfg.step), .rate (cfg.rate[1]),
    .actual_next (act_next[1]), .settled_next (set_next[1])
  );

  sscl_joint #(.MAX(ELBOW_MAX), .RESET_ANGLE(ELBOW_RESET)) u_elbow (
    .clk (clk), .rst (rst), .advance (advance), .func (s1.func), .cmd (cmd[2]),
    .step (cfg.step), .rate (cfg.rate[2]),
    .actual_next (act_next[2]), .settled_next (set_next[2])
  );

  sscl_joint #(.MAX(CLAMP_MAX), .RESET_ANGLE(CLAMP_RESET)) u_clamp (
    .clk (clk), .rst (rst), .advance (advance), .func (s1.func), .cmd (cmd[3]),
    .step (cfg.step), .rate (cfg.rate[3]),
    .actual_next (act_next[3]), .settled_next (set_next[3])
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.base_angle     <= act_next[0];
      out_data.shoulder_angle <= act_next[1];
      out_data.elbow_angle    <= act_next[2];
      out_data.clamp_angle    <= act_next[3];
      out_data.all_settled    <= &set_next;
    end
  end

  // An empty input register never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  // An advancing beat always lands in the result register
  a_advance_loads_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat did not reach result register");

  // A held beat is not dropped from the input register
  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("held beat lost from input register");

  // A full, stalled result register blocks the advance
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("advance while result register stalled");

endmodule

### tb/tb_four_axis_servo_slew_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_axis_servo_slew_control
// Self-checking bench for the four-joint servo slew-rate limiter. A directed
// table covers reset values, threshold edges, button order, clamping and the
// unused function code. Random phases follow, each under its own register
// settings. Every accepted result is compared with an in-bench joint model or,
// for some directed rows, with a fixed expectation. Both channels idle at random,
// and the result side holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_four_axis_servo_slew_control;
  import sscl_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BEATS = 240;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;

  localparam int J_BASE     = 0;
  localparam int J_SHOULDER = 1;
  localparam int J_ELBOW    = 2;
  localparam int J_CLAMP    = 3;

  // Function code with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_UPPER;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Joint model: targets, actual angles and register copies
  logic [ANGLE_W-1:0] aim [NUM_JOINTS];
  logic [ANGLE_W-1:0] pos [NUM_JOINTS];
  int                 joint_lim [NUM_JOINTS];
  int                 up_thr;
  int                 lo_thr;
  int                 tgt_step;
  int                 slew_rate [NUM_JOINTS];

  out_item_t expected_angles_q[$];
  dir_row_t  dir_rows[$];
  int        err_count   = 0;
  int        result_no   = 0;
  int        cycle_count = 0;
  int        tx_idle_pct = 25;
  int        rx_idle_pct = 25;
  bit        hold_req    = 1'b0;

  four_axis_servo_slew_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL four_axis_servo_slew_control");
      $finish;
    end
  end

  // Idle length: mostly none, mostly short otherwise, now and then long
  function automatic int idle_len(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [ANGLE_W-1:0] target_up(logic [ANGLE_W-1:0] t, int lim);
    int v;
    v = int'(t) + tgt_step;
    return (v > lim) ? lim[ANGLE_W-1:0] : v[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] target_down(logic [ANGLE_W-1:0] t);
    return (int'(t) > tgt_step) ? t - tgt_step[ANGLE_W-1:0] : '0;
  endfunction

  // Step one actual angle toward its target, wrapping at 8 bits
  task automatic slew_joint(int j);
    if (pos[j] > aim[j]) pos[j] = pos[j] - slew_rate[j][ANGLE_W-1:0];
    else pos[j] = pos[j] + slew_rate[j][ANGLE_W-1:0];
  endtask

  task automatic reset_joints();
    joint_lim[J_BASE]     = BASE_MAX_DEF;
    joint_lim[J_SHOULDER] = SHOULDER_MAX_DEF;
    joint_lim[J_ELBOW]    = ELBOW_MAX_DEF;
    joint_lim[J_CLAMP]    = CLAMP_MAX_DEF;
    aim[J_BASE]     = BASE_RESET;
    aim[J_SHOULDER] = SHOULDER_RESET;
    aim[J_ELBOW]    = ELBOW_RESET;
    aim[J_CLAMP]    = CLAMP_RESET;
    for (int j = 0; j < NUM_JOINTS; j++) pos[j] = aim[j];
    up_thr   = UPPER_RESET;
    lo_thr   = LOWER_RESET;
    tgt_step = STEP_RESET;
    slew_rate[J_BASE]     = BASE_RATE_RESET;
    slew_rate[J_SHOULDER] = SHOULDER_RATE_RESET;
    slew_rate[J_ELBOW]    = ELBOW_RATE_RESET;
    slew_rate[J_CLAMP]    = CLAMP_RATE_RESET;
  endtask

  // Advance the joint model by one beat and form the angles it reports
  task automatic predict_angles(input in_item_t it, output out_item_t r);
    int d;
    bit settled;
    case (it.func)
      FUNC_SAMPLE: begin
        if (int'(it.stick_x) > up_thr) aim[J_BASE] = target_up(aim[J_BASE], joint_lim[J_BASE]);
        else if (int'(it.stick_x) < lo_thr) aim[J_BASE] = target_down(aim[J_BASE]);
        if (int'(it.stick_y) > up_thr) begin
          aim[J_SHOULDER] = target_up(aim[J_SHOULDER], joint_lim[J_SHOULDER]);
        end else if (int'(it.stick_y) < lo_thr) begin
          aim[J_SHOULDER] = target_down(aim[J_SHOULDER]);
        end
        // Elbow: down then up; clamp: open then close
        if (it.elbow_down_pressed) aim[J_ELBOW] = target_down(aim[J_ELBOW]);
        if (it.elbow_up_pressed) aim[J_ELBOW] = target_up(aim[J_ELBOW], joint_lim[J_ELBOW]);
        if (it.clamp_open_pressed) aim[J_CLAMP] = target_up(aim[J_CLAMP], joint_lim[J_CLAMP]);
        if (it.clamp_close_pressed) aim[J_CLAMP] = target_down(aim[J_CLAMP]);
      end
      FUNC_MOVE: begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
          d = (pos[j] > aim[j]) ? int'(pos[j]) - int'(aim[j]) : int'(aim[j]) - int'(pos[j]);
          if (d > 2 * slew_rate[j]) slew_joint(j);
        end
      end
      FUNC_SETTLE: begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
          if (pos[j] != aim[j]) slew_joint(j);
        end
      end
      default: ;
    endcase
    settled = 1'b1;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      if (pos[j] != aim[j]) settled = 1'b0;
    end
    r.base_angle     = pos[J_BASE];
    r.shoulder_angle = pos[J_SHOULDER];
    r.elbow_angle    = pos[J_ELBOW];
    r.clamp_angle    = pos[J_CLAMP];
    r.all_settled    = settled;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("[%0t] result %0d %s: got %0d, expected %0d", $realtime, result_no, what,
               got, want);
    end
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_angles(out_item_t got);
    out_item_t want;
    if (expected_angles_q.size() == 0) begin
      report_mismatch("unexpected beat, base", got.base_angle, -1);
    end else begin
      want = expected_angles_q.pop_front();
      if (got.base_angle !== want.base_angle)
        report_mismatch("base_angle", got.base_angle, want.base_angle);
      if (got.shoulder_angle !== want.shoulder_angle)
        report_mismatch("shoulder_angle", got.shoulder_angle, want.shoulder_angle);
      if (got.elbow_angle !== want.elbow_angle)
        report_mismatch("elbow_angle", got.elbow_angle, want.elbow_angle);
      if (got.clamp_angle !== want.clamp_angle)
        report_mismatch("clamp_angle", got.clamp_angle, want.clamp_angle);
      if (got.all_settled !== want.all_settled)
        report_mismatch("all_settled", got.all_settled, want.all_settled);
    end
    result_no++;
  endtask

  // Result side: check accepted beats, stall at random, hold off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_angles(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len(rx_idle_pct);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offer one beat, hold it until accepted, then maybe idle
  task automatic send_beat(in_item_t it, bit typed, out_item_t fixed);
    out_item_t pred;
    int        gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_angles(it, pred);
    expected_angles_q.push_back(typed ? fixed : pred);
    gap = idle_len(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every expected beat
  task automatic drain_results(int extra);
    in_valid <= 1'b0;
    while (expected_angles_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_UPPER:         up_thr = val;
      CFG_LOWER:         lo_thr = val;
      CFG_STEP:          tgt_step = val;
      CFG_BASE_RATE:     slew_rate[J_BASE] = val;
      CFG_SHOULDER_RATE: slew_rate[J_SHOULDER] = val;
      CFG_ELBOW_RATE:    slew_rate[J_ELBOW] = val;
      CFG_CLAMP_RATE:    slew_rate[J_CLAMP] = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(int up, int lo, int st, int r0, int r1, int r2, int r3);
    write_reg(CFG_UPPER, up);
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_STEP, st);
    write_reg(CFG_BASE_RATE, r0);
    write_reg(CFG_SHOULDER_RATE, r1);
    write_reg(CFG_ELBOW_RATE, r2);
    write_reg(CFG_CLAMP_RATE, r3);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk_item(logic [1:0] f, int x, int y, bit ed, bit eu,
                                       bit co, bit cc);
    in_item_t it;
    it.func                = f;
    it.stick_x             = x[STICK_W-1:0];
    it.stick_y             = y[STICK_W-1:0];
    it.elbow_down_pressed  = ed;
    it.elbow_up_pressed    = eu;
    it.clamp_open_pressed  = co;
    it.clamp_close_pressed = cc;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Stick readings: extremes, threshold neighbors, or anywhere
  function automatic int pick_stick();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = (1 << STICK_W) - 1;
      2: v = up_thr + $urandom_range(0, 2) - 1;
      3: v = lo_thr + $urandom_range(0, 2) - 1;
      default: v = $urandom_range(0, (1 << STICK_W) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << STICK_W) - 1) v = (1 << STICK_W) - 1;
    return v;
  endfunction

  function automatic in_item_t rand_item();
    int         r;
    logic [1:0] f;
    r = $urandom_range(0, 99);
    if (r < 45) f = FUNC_SAMPLE;
    else if (r < 75) f = FUNC_MOVE;
    else if (r < 95) f = FUNC_SETTLE;
    else f = FUNC_UNUSED;
    return mk_item(f, pick_stick(), pick_stick(), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  function automatic int rand_rate();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 8);
  endfunction

  // Main sequence
  initial begin
    out_item_t none;
    out_item_t home_settled;
    out_item_t home_moving;
    none         = '0;
    home_settled = '{8'd0, 8'd0, 8'd160, 8'd92, 1'b1};
    home_moving  = '{8'd0, 8'd0, 8'd160, 8'd92, 1'b0};
    reset_joints();

    // Directed table under reset settings
    add_row(mk_item(FUNC_SAMPLE, 512, 512, 0, 0, 0, 0), 1'b1, home_settled);
    add_row(mk_item(FUNC_UNUSED, 1023, 1023, 1, 1, 1, 1), 1'b1, home_settled);
    add_row(mk_item(FUNC_SETTLE, 0, 0, 0, 0, 0, 0), 1'b1, home_settled);
    add_row(mk_item(FUNC_SAMPLE, 1023, 1023, 1, 1, 1, 1), 1'b1, home_moving);
    add_row(mk_item(FUNC_SAMPLE, 0, 0, 0, 0, 0, 0), 1'b1, home_settled);
    add_row(mk_item(FUNC_SAMPLE, 681, 681, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 680, 340, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 340, 680, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 339, 339, 0, 0, 0, 0), 1'b0, none);
    for (int i = 0; i < 5; i++) add_row(mk_item(FUNC_SAMPLE, 1023, 1023, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_MOVE, 0, 0, 1, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_MOVE, 0, 0, 0, 1, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 512, 512, 1, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 512, 512, 0, 0, 0, 1), 1'b0, none);
    add_row(mk_item(FUNC_SETTLE, 512, 512, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SAMPLE, 512, 512, 0, 1, 1, 0), 1'b0, none);
    add_row(mk_item(FUNC_SETTLE, 0, 0, 0, 0, 1, 1), 1'b0, none);
    add_row(mk_item(FUNC_MOVE, 1023, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_SETTLE, 0, 1023, 0, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_UNUSED, 0, 0, 0, 0, 0, 0), 1'b0, none);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain_results(4);

    // Random phases, each under fresh register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: load_settings(680, 340, 4, 4, 1, 1, 4);
        1: load_settings(0, 1023, 255, 0, 0, 0, 0);
        2: load_settings(1023, 0, 0, 255, 255, 255, 255);
        3: load_settings(0, 0, 255, 255, 0, 255, 0);
        default: load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(1, 20), rand_rate(), rand_rate(),
                               rand_rate(), rand_rate());
      endcase
      tx_idle_pct = (ph % 3 == 0) ? 0 : 25;
      rx_idle_pct = (ph % 4 == 1) ? 0 : 25;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Back the block up with a long hold on the result side
        if (ph == 4 && n == 20) hold_req = 1'b1;
        // Let the pipeline empty out mid-phase
        if (ph == 5 && n == PHASE_BEATS / 2) drain_results(0);
        send_beat(rand_item(), 1'b0, none);
      end
      drain_results(4);
    end

    drain_results(20);
    if (err_count == 0) begin
      $display("PASS four_axis_servo_slew_control");
    end else begin
      $display("FAIL four_axis_servo_slew_control");
    end
    $finish;
  end

endmodule
